/* rtl/core/onsc_pkg.sv */
package onsc_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int AMP_BITS       = SAMPLE_BITS + 1;
	localparam int RSSI_BITS      = 21;
	localparam int COUNT_BITS     = 21;
	localparam int FFT_BITS       = 12;
	localparam int GUARD_BITS     = 10;
	localparam int SYM_BITS       = 8;
	localparam int OFFSET_BITS    = 10;
	localparam int LIMIT_BITS     = 21;
	localparam int POS_BITS       = 11;
	localparam int THR_BITS       = 20;
	localparam int CFG_DATA_BITS  = 21;
	localparam int CFG_INDEX_BITS = 3;
	localparam int FORGET_SHIFT   = 3;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_BITS      = 2;

	localparam logic [RSSI_BITS-1:0]  RSSI_RESET = RSSI_BITS'(2000);
	localparam logic [RSSI_BITS-1:0]  RSSI_MAX   = {RSSI_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
	localparam logic [FFT_BITS-1:0]   FFT_MAX    = FFT_BITS'(2048);

	localparam logic [FFT_BITS-1:0]    FFT_RESET    = FFT_BITS'(2048);
	localparam logic [GUARD_BITS-1:0]  GUARD_RESET  = GUARD_BITS'(504);
	localparam logic [SYM_BITS-1:0]    SYM_RESET    = SYM_BITS'(76);
	localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(150);
	localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = LIMIT_BITS'(2000000);
	localparam logic [THR_BITS-1:0]    THR_RESET    = THR_BITS'(76 * (504 + 2048));

	localparam logic [CFG_INDEX_BITS-1:0] REG_FFT_LENGTH      = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_GUARD_LENGTH    = CFG_INDEX_BITS'(1);
	localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOLS         = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_OFFSET    = CFG_INDEX_BITS'(3);
	localparam logic [CFG_INDEX_BITS-1:0] REG_NO_SIGNAL_LIMIT = CFG_INDEX_BITS'(4);

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_OFFSET,
		PH_SYMBOL,
		PH_GUARD
	} phase_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_i;
		logic signed [SAMPLE_BITS-1:0] sample_q;
	} sample_t;

	typedef struct packed {
		logic                          out_valid;
		logic signed [SAMPLE_BITS-1:0] out_i;
		logic signed [SAMPLE_BITS-1:0] out_q;
		logic                          first_symbol;
		logic                          last_of_window;
		logic                          frame_detected;
		logic                          no_signal;
	} result_t;

	typedef struct packed {
		sample_t             smp;
		logic [AMP_BITS-1:0] amp;
	} work_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

	function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] x);
		logic [SAMPLE_BITS-1:0] m;
		m = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
		return m;
	endfunction

	// doubled max + min/2 estimate
	function automatic logic [AMP_BITS-1:0] amplitude(input sample_t s);
		logic [SAMPLE_BITS-1:0] ai;
		logic [SAMPLE_BITS-1:0] aq;
		logic [AMP_BITS-1:0]    a;
		ai = magnitude(s.sample_i);
		aq = magnitude(s.sample_q);
		if (ai > aq) begin
			a = {ai, 1'b0} + {1'b0, aq};
		end else begin
			a = {aq, 1'b0} + {1'b0, ai};
		end
		return a;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

/* rtl/core/onsc_front.sv */
module onsc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  onsc_pkg::sample_t    sample,
	input  onsc_pkg::q_status_t  q_status,
	output logic                 push,
	output onsc_pkg::work_t      push_data
);

	logic            valid_s1;
	onsc_pkg::work_t work_s1;
	logic            accept;

	assign push         = valid_s1 && !q_status.full;
	assign sample_stall = valid_s1 && q_status.full;
	assign accept       = sample_valid && !sample_stall;
	assign push_data    = work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1.smp <= sample;
			work_s1.amp <= onsc_pkg::amplitude(sample);
		end
	end

endmodule

/* rtl/core/onsc_queue.sv */
module onsc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  onsc_pkg::work_t      push_data,
	input  logic                 pop,
	output onsc_pkg::work_t      pop_data,
	output onsc_pkg::q_status_t  status
);

	onsc_pkg::work_t                  entries_q [onsc_pkg::QUEUE_DEPTH];
	logic [onsc_pkg::QPTR_BITS-1:0]   wr_ptr_q;
	logic [onsc_pkg::QPTR_BITS-1:0]   rd_ptr_q;
	logic [onsc_pkg::QPTR_BITS:0]     count_q;

	assign pop_data         = entries_q[rd_ptr_q];
	assign status.full      = (count_q == (onsc_pkg::QPTR_BITS + 1)'(onsc_pkg::QUEUE_DEPTH));
	assign status.not_empty = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/onsc_back.sv */
module onsc_back #(
	parameter int DELAY_DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write_en,
	input  logic [onsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [onsc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  onsc_pkg::q_status_t                    q_status,
	output logic                                   pop,
	input  onsc_pkg::work_t                        pop_data,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output onsc_pkg::result_t                      result
);

	localparam int PW = (DELAY_DEPTH > 2) ? $clog2(DELAY_DEPTH) : 1;
	localparam logic [PW-1:0] PTR_LAST = PW'(DELAY_DEPTH - 1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [onsc_pkg::FFT_BITS-1:0]    fft_length_q;
	logic [onsc_pkg::GUARD_BITS-1:0]  guard_length_q;
	logic [onsc_pkg::SYM_BITS-1:0]    symbols_q;
	logic [onsc_pkg::OFFSET_BITS-1:0] start_offset_q;
	logic [onsc_pkg::LIMIT_BITS-1:0]  limit_q;
	logic [onsc_pkg::THR_BITS-1:0]    thr_q;
	logic [onsc_pkg::FFT_BITS-1:0]    wlen;
	logic [onsc_pkg::FFT_BITS-1:0]    gsum;

	// sequencer state
	onsc_pkg::phase_t                  phase_q, phase_d;
	logic [onsc_pkg::COUNT_BITS-1:0]   count_q, count_d;
	logic [onsc_pkg::SYM_BITS-1:0]     idx_q, idx_d;
	logic [onsc_pkg::POS_BITS-1:0]     pos_q, pos_d;
	logic [onsc_pkg::RSSI_BITS-1:0]    rssi_q;
	onsc_pkg::result_t                 res_d, res_q;
	logic                              res_valid_q;

	// delay ring
	logic [onsc_pkg::RSSI_BITS-1:0]    ring_q [DELAY_DEPTH];
	logic [PW-1:0]                     ptr_q, ptr_nx, rd_addr;
	logic                              wrapped_q, wrapped_nx;
	logic                              ring_we, rd_written, bypass;
	logic [onsc_pkg::RSSI_BITS-1:0]    head_mem_q, head_alt_q, head;
	logic                              head_use_mem_q;

	logic                              fire;
	logic [onsc_pkg::RSSI_BITS:0]      lvl_sum;
	logic [onsc_pkg::RSSI_BITS-1:0]    lvl;
	logic                              detect;

	assign wlen = (fft_length_q == '0) ? onsc_pkg::FFT_BITS'(1) :
	              (fft_length_q > onsc_pkg::FFT_MAX) ? onsc_pkg::FFT_MAX : fft_length_q;
	assign gsum = onsc_pkg::FFT_BITS'(guard_length_q) + wlen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_length_q   <= onsc_pkg::FFT_RESET;
			guard_length_q <= onsc_pkg::GUARD_RESET;
			symbols_q      <= onsc_pkg::SYM_RESET;
			start_offset_q <= onsc_pkg::OFFSET_RESET;
			limit_q        <= onsc_pkg::LIMIT_RESET;
			thr_q          <= onsc_pkg::THR_RESET;
		end else begin
			thr_q <= onsc_pkg::THR_BITS'(symbols_q) * onsc_pkg::THR_BITS'(gsum);
			if (cfg_write_en) begin
				case (cfg_index)
					onsc_pkg::REG_FFT_LENGTH:
						fft_length_q <= cfg_data[onsc_pkg::FFT_BITS-1:0];
					onsc_pkg::REG_GUARD_LENGTH:
						guard_length_q <= cfg_data[onsc_pkg::GUARD_BITS-1:0];
					onsc_pkg::REG_SYMBOLS:
						symbols_q <= cfg_data[onsc_pkg::SYM_BITS-1:0];
					onsc_pkg::REG_START_OFFSET:
						start_offset_q <= cfg_data[onsc_pkg::OFFSET_BITS-1:0];
					onsc_pkg::REG_NO_SIGNAL_LIMIT:
						limit_q <= cfg_data[onsc_pkg::LIMIT_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	// one request per cycle while the queue is not empty and the result register can take it
	assign fire         = q_status.not_empty && (!res_valid_q || !result_stall);
	assign pop          = fire;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign lvl_sum = (onsc_pkg::RSSI_BITS + 1)'(rssi_q)
	               - (onsc_pkg::RSSI_BITS + 1)'(rssi_q >> onsc_pkg::FORGET_SHIFT)
	               + (onsc_pkg::RSSI_BITS + 1)'(pop_data.amp);
	assign lvl     = lvl_sum[onsc_pkg::RSSI_BITS] ? onsc_pkg::RSSI_MAX
	                                              : lvl_sum[onsc_pkg::RSSI_BITS-1:0];
	assign head    = head_use_mem_q ? head_mem_q : head_alt_q;
	assign detect  = (head < onsc_pkg::RSSI_BITS'(pop_data.amp))
	              && (count_q > onsc_pkg::COUNT_BITS'(thr_q));

	always_comb begin
		logic                              win;
		logic [onsc_pkg::COUNT_BITS-1:0]   b_count;
		logic [onsc_pkg::POS_BITS-1:0]     b_pos;
		logic [onsc_pkg::SYM_BITS-1:0]     b_idx;
		logic [onsc_pkg::SYM_BITS-1:0]     idx1;
		logic [onsc_pkg::COUNT_BITS-1:0]   c;
		logic [onsc_pkg::POS_BITS:0]       p1;
		logic [onsc_pkg::OFFSET_BITS-1:0]  len;

		phase_d = phase_q;
		count_d = count_q;
		idx_d   = idx_q;
		pos_d   = pos_q;
		res_d   = '0;
		win     = 1'b0;
		b_count = count_q;
		b_pos   = pos_q;
		b_idx   = idx_q;
		idx1    = '0;
		c       = '0;
		p1      = '0;
		len     = '0;

		case (phase_q)
			onsc_pkg::PH_SEARCH: begin
				idx_d = '0;
				if (detect) begin
					res_d.frame_detected = 1'b1;
					count_d = '0;
					if (start_offset_q == '0) begin
						// detecting sample opens the first window
						win     = 1'b1;
						b_count = '0;
						b_pos   = '0;
						b_idx   = '0;
					end else begin
						// detecting sample is the first offset sample
						count_d = onsc_pkg::COUNT_BITS'(1);
						if (start_offset_q == onsc_pkg::OFFSET_BITS'(1)) begin
							phase_d = onsc_pkg::PH_SYMBOL;
							pos_d   = '0;
						end else begin
							phase_d = onsc_pkg::PH_OFFSET;
							pos_d   = onsc_pkg::POS_BITS'(1);
						end
					end
				end else begin
					c = onsc_pkg::sat_inc(count_q);
					if (c >= limit_q) begin
						count_d         = '0;
						res_d.no_signal = 1'b1;
					end else begin
						count_d = c;
					end
				end
			end
			onsc_pkg::PH_OFFSET, onsc_pkg::PH_GUARD: begin
				len     = (phase_q == onsc_pkg::PH_OFFSET) ? start_offset_q : guard_length_q;
				count_d = onsc_pkg::sat_inc(count_q);
				p1      = {1'b0, pos_q} + 1'b1;
				if (p1 >= (onsc_pkg::POS_BITS + 1)'(len)) begin
					phase_d = onsc_pkg::PH_SYMBOL;
					pos_d   = '0;
				end else begin
					pos_d = p1[onsc_pkg::POS_BITS-1:0];
				end
			end
			onsc_pkg::PH_SYMBOL: begin
				win = 1'b1;
			end
			default: ;
		endcase

		if (win) begin
			res_d.out_valid    = 1'b1;
			res_d.out_i        = pop_data.smp.sample_i;
			res_d.out_q        = pop_data.smp.sample_q;
			res_d.first_symbol = (b_idx == '0);
			count_d            = onsc_pkg::sat_inc(b_count);
			p1                 = {1'b0, b_pos} + 1'b1;
			if (p1 >= wlen) begin
				res_d.last_of_window = 1'b1;
				idx1 = b_idx + 1'b1;
				if (idx1 >= symbols_q) begin
					phase_d = onsc_pkg::PH_SEARCH;
					pos_d   = '0;
					idx_d   = '0;
				end else begin
					idx_d   = idx1;
					pos_d   = '0;
					phase_d = (guard_length_q == '0) ? onsc_pkg::PH_SYMBOL : onsc_pkg::PH_GUARD;
				end
			end else begin
				phase_d = onsc_pkg::PH_SYMBOL;
				pos_d   = p1[onsc_pkg::POS_BITS-1:0];
				idx_d   = b_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= onsc_pkg::PH_SEARCH;
			count_q     <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			rssi_q      <= onsc_pkg::RSSI_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				count_q <= count_d;
				idx_q   <= idx_d;
				pos_q   <= pos_d;
				if (phase_q == onsc_pkg::PH_SEARCH) begin
					rssi_q <= lvl;
				end
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	// ring: head holds the oldest entry, prefetched one request ahead.
	// Entries not yet written read as the reset level (writes run in order from 0).
	assign ring_we    = fire && (phase_q == onsc_pkg::PH_SEARCH);
	assign ptr_nx     = ring_we ? ptr_inc(ptr_q) : ptr_q;
	assign rd_addr    = ptr_inc(ptr_nx);
	assign wrapped_nx = wrapped_q || (ring_we && (ptr_q == PTR_LAST));
	assign rd_written = wrapped_nx || (rd_addr < ptr_nx);
	assign bypass     = ring_we && (rd_addr == ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q          <= '0;
			wrapped_q      <= 1'b0;
			head_use_mem_q <= 1'b0;
			head_alt_q     <= onsc_pkg::RSSI_RESET;
		end else begin
			ptr_q          <= ptr_nx;
			wrapped_q      <= wrapped_nx;
			head_use_mem_q <= rd_written && !bypass;
			head_alt_q     <= bypass ? lvl : onsc_pkg::RSSI_RESET;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_q[ptr_q] <= lvl;
		end
		head_mem_q <= ring_q[rd_addr];
	end

endmodule

/* rtl/core/ofdm_null_symbol_sync_cutter.sv */
// A request passes the front-end register, the queue and the result register in order.
// Throughput: one sample per cycle while result_stall is low; the level loop and the
// ring write (one per request) advance only in search, the prefetch read every cycle.
// A four-entry queue sits between the amplitude front end and the sequencer.
// Reset (arst_n low) returns to search with the registers at their defaults;
// the delay ring reads as the reset level until filled, with no clearing pass.
module ofdm_null_symbol_sync_cutter #(
	parameter int DELAY_DEPTH = 128
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  onsc_pkg::sample_t                   sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output onsc_pkg::result_t                   result,
	input  logic                                cfg_write_en,
	input  logic [onsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [onsc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	logic                push;
	logic                pop;
	onsc_pkg::work_t     push_data;
	onsc_pkg::work_t     pop_data;
	onsc_pkg::q_status_t q_status;

	onsc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.q_status     (q_status),
		.push         (push),
		.push_data    (push_data)
	);

	onsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	onsc_back #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_status     (q_status),
		.pop          (pop),
		.pop_data     (pop_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// an accepted request must be pushed into the queue on the next cycle unless the queue is full
	a_front_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> (push || q_status.full))
		else $error("accepted request not moving to the queue");

	a_detect_first: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_detected && result.out_valid) |-> result.first_symbol)
		else $error("window opened on detection is not the first symbol");

	a_no_signal_search: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.no_signal) |-> (!result.out_valid && !result.frame_detected))
		else $error("no-signal flagged outside plain search");

endmodule
